// ===== rtl/mahony_quaternion_attitude_update_top_macros.svh =====
// ----------------------------------------------------------------------------
// mahony attitude update assertion macros
// shorthand for clocked assertions on aclk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef MAHONY_QUATERNION_ATTITUDE_UPDATE_TOP_MACROS_SVH
`define MAHONY_QUATERNION_ATTITUDE_UPDATE_TOP_MACROS_SVH

// same-cycle implication
`define MQA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MQA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mqa_pkg.sv =====
// ----------------------------------------------------------------------------
// mqa_pkg
// types, constants and the microprogram of the mahony attitude update
// ----------------------------------------------------------------------------
`default_nettype none

package mqa_pkg;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [31:0] HALF_Q30 = 32'sh2000_0000;
    localparam logic signed [70:0] MAX32 = 71'sd2147483647;
    localparam logic signed [70:0] MIN32 = -71'sd2147483648;
    localparam logic signed [70:0] POS1 = 71'sd1073741824;
    localparam logic signed [70:0] NEG1 = -71'sd1073741824;

    // register indexes on the configuration port
    localparam logic [1:0] REG_PROP_GAIN = 2'd0;
    localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

    // microprogram landmarks
    localparam logic [5:0] PC_END_SQ = 6'd2;
    localparam logic [5:0] PC_SEG_VE = 6'd3;
    localparam logic [5:0] PC_SEG_G = 6'd23;
    localparam logic [5:0] PC_END_G = 6'd38;
    localparam int UCODE_LEN = 64;

    typedef enum logic [5:0] {
        OP_Q0, OP_Q1, OP_Q2, OP_Q3,
        OP_AX, OP_AY, OP_AZ,
        OP_U0, OP_U1, OP_U2,
        OP_V0, OP_V1, OP_V2,
        OP_E0, OP_E1, OP_E2,
        OP_I0, OP_I1, OP_I2,
        OP_R0, OP_R1, OP_R2,
        OP_G,
        OP_TH0, OP_TH1, OP_TH2,
        OP_D,
        OP_T0, OP_T1, OP_T2, OP_T3,
        OP_NQ0, OP_NQ1, OP_NQ2, OP_NQ3,
        OP_KP, OP_KI, OP_DT,
        OP_CA, OP_CB,
        OP_ONE, OP_C256
    } opnd_t;

    typedef enum logic [1:0] {AM_LOAD, AM_LOADN, AM_ADD, AM_SUB} acc_mode_t;

    typedef enum logic [1:0] {SH_0, SH_2, SH_18, SH_30} shift_t;

    typedef enum logic [4:0] {
        DS_NONE,
        DS_V0, DS_V1, DS_V2,
        DS_E0, DS_E1, DS_E2,
        DS_I0, DS_I1, DS_I2,
        DS_G,
        DS_TH0, DS_TH1, DS_TH2,
        DS_D, DS_D2,
        DS_T0, DS_T1, DS_T2, DS_T3,
        DS_NQ0, DS_NQ1, DS_NQ2, DS_NQ3
    } dest_t;

    typedef enum logic [2:0] {PS_NONE, PS_SAT, PS_SAT2, PS_CLAMP1, PS_ASR30} post_t;

    typedef struct packed {
        opnd_t     a;
        opnd_t     b;
        acc_mode_t mode;
        shift_t    sh;
        dest_t     dst;
        post_t     post;
        logic      last;
    } uop_t;

    localparam uop_t UCODE [UCODE_LEN] = '{
        // sum of squares of the accel sample
        '{OP_AX,  OP_AX,   AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_AY,  OP_AY,   AM_ADD,   SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_AZ,  OP_AZ,   AM_ADD,   SH_0,  DS_NONE, PS_NONE,   1'b1},
        // predicted gravity
        '{OP_Q1,  OP_Q3,   AM_LOAD,  SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_Q0,  OP_Q2,   AM_SUB,   SH_30, DS_V0,   PS_SAT2,   1'b0},
        '{OP_Q0,  OP_Q1,   AM_LOAD,  SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_Q2,  OP_Q3,   AM_ADD,   SH_30, DS_V1,   PS_SAT2,   1'b0},
        '{OP_Q0,  OP_Q0,   AM_LOAD,  SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_Q1,  OP_Q1,   AM_SUB,   SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_Q2,  OP_Q2,   AM_SUB,   SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_Q3,  OP_Q3,   AM_ADD,   SH_30, DS_V2,   PS_SAT,    1'b0},
        // error cross product
        '{OP_U1,  OP_V2,   AM_LOAD,  SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_U2,  OP_V1,   AM_SUB,   SH_30, DS_E0,   PS_SAT,    1'b0},
        '{OP_U2,  OP_V0,   AM_LOAD,  SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_U0,  OP_V2,   AM_SUB,   SH_30, DS_E1,   PS_SAT,    1'b0},
        '{OP_U0,  OP_V1,   AM_LOAD,  SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_U1,  OP_V0,   AM_SUB,   SH_30, DS_E2,   PS_SAT,    1'b0},
        // integral terms
        '{OP_I0,  OP_ONE,  AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_KI,  OP_E0,   AM_ADD,   SH_30, DS_I0,   PS_SAT,    1'b0},
        '{OP_I1,  OP_ONE,  AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_KI,  OP_E1,   AM_ADD,   SH_30, DS_I1,   PS_SAT,    1'b0},
        '{OP_I2,  OP_ONE,  AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_KI,  OP_E2,   AM_ADD,   SH_30, DS_I2,   PS_SAT,    1'b0},
        // corrected rates and rotation increments
        '{OP_R0,  OP_C256, AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_KP,  OP_E0,   AM_ADD,   SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_I0,  OP_ONE,  AM_ADD,   SH_0,  DS_G,    PS_SAT,    1'b0},
        '{OP_G,   OP_DT,   AM_LOAD,  SH_18, DS_TH0,  PS_CLAMP1, 1'b0},
        '{OP_R1,  OP_C256, AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_KP,  OP_E1,   AM_ADD,   SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_I1,  OP_ONE,  AM_ADD,   SH_0,  DS_G,    PS_SAT,    1'b0},
        '{OP_G,   OP_DT,   AM_LOAD,  SH_18, DS_TH1,  PS_CLAMP1, 1'b0},
        '{OP_R2,  OP_C256, AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_KP,  OP_E2,   AM_ADD,   SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_I2,  OP_ONE,  AM_ADD,   SH_0,  DS_G,    PS_SAT,    1'b0},
        '{OP_G,   OP_DT,   AM_LOAD,  SH_18, DS_TH2,  PS_CLAMP1, 1'b0},
        // rotation angle squared and its square
        '{OP_TH0, OP_TH0,  AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_TH1, OP_TH1,  AM_ADD,   SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_TH2, OP_TH2,  AM_ADD,   SH_0,  DS_D,    PS_ASR30,  1'b0},
        '{OP_D,   OP_D,    AM_LOAD,  SH_0,  DS_D2,   PS_ASR30,  1'b1},
        // quaternion rate products
        '{OP_Q1,  OP_TH0,  AM_LOADN, SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_Q2,  OP_TH1,  AM_SUB,   SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_Q3,  OP_TH2,  AM_SUB,   SH_0,  DS_T0,   PS_ASR30,  1'b0},
        '{OP_Q0,  OP_TH0,  AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_Q2,  OP_TH2,  AM_ADD,   SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_Q3,  OP_TH1,  AM_SUB,   SH_0,  DS_T1,   PS_ASR30,  1'b0},
        '{OP_Q0,  OP_TH1,  AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_Q1,  OP_TH2,  AM_SUB,   SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_Q3,  OP_TH0,  AM_ADD,   SH_0,  DS_T2,   PS_ASR30,  1'b0},
        '{OP_Q0,  OP_TH2,  AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_Q1,  OP_TH1,  AM_ADD,   SH_0,  DS_NONE, PS_NONE,   1'b0},
        '{OP_Q2,  OP_TH0,  AM_SUB,   SH_0,  DS_T3,   PS_ASR30,  1'b0},
        // series integration
        '{OP_CA,  OP_Q0,   AM_LOAD,  SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_CB,  OP_T0,   AM_ADD,   SH_30, DS_NQ0,  PS_SAT,    1'b0},
        '{OP_CA,  OP_Q1,   AM_LOAD,  SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_CB,  OP_T1,   AM_ADD,   SH_30, DS_NQ1,  PS_SAT,    1'b0},
        '{OP_CA,  OP_Q2,   AM_LOAD,  SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_CB,  OP_T2,   AM_ADD,   SH_30, DS_NQ2,  PS_SAT,    1'b0},
        '{OP_CA,  OP_Q3,   AM_LOAD,  SH_30, DS_NONE, PS_NONE,   1'b0},
        '{OP_CB,  OP_T3,   AM_ADD,   SH_30, DS_NQ3,  PS_SAT,    1'b0},
        // norm for renormalization
        '{OP_NQ0, OP_NQ0,  AM_LOAD,  SH_2,  DS_NONE, PS_NONE,   1'b0},
        '{OP_NQ1, OP_NQ1,  AM_ADD,   SH_2,  DS_NONE, PS_NONE,   1'b0},
        '{OP_NQ2, OP_NQ2,  AM_ADD,   SH_2,  DS_NONE, PS_NONE,   1'b0},
        '{OP_NQ3, OP_NQ3,  AM_ADD,   SH_2,  DS_NONE, PS_NONE,   1'b1},
        // spare slot
        '{OP_ONE, OP_ONE,  AM_LOAD,  SH_0,  DS_NONE, PS_NONE,   1'b1}
    };

    function automatic logic signed [33:0] clamp71(input logic signed [70:0] x,
                                                   input logic signed [70:0] lo,
                                                   input logic signed [70:0] hi);
        logic signed [70:0] r;
        r = (x < lo) ? lo : ((x > hi) ? hi : x);
        return r[33:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mahony_quaternion_attitude_update_top.sv =====
// ----------------------------------------------------------------------------
// mahony quaternion attitude update
// One transfer on the s_ channel carries one IMU sample (gyro rates in Q8.16,
// raw accelerometer counts); one transfer on the m_ channel returns the new
// attitude quaternion in Q2.30 and a flag that is set when the accelerometer
// vector was zero and the correction was skipped. The gains and the sample
// period are written over the cfg_ channel (Q8.24); the user must write them
// only while the block is idle, which the block itself does not enforce.
// All arithmetic runs on one 34x34 signed multiplier with a 70-bit accumulator
// under a microprogram, one 31-step restoring divider and one 32-step bitwise
// square root. The two series coefficients need a division by three, which
// comes from a constant reciprocal product. Each item is taken in, then
// passes through the microprogram, the two roots, the seven divisions, which
// dominate, and the two series coefficients before the output register is
// loaded; a zero accelerometer vector skips the root, three divisions and 20
// products. s_ready is high only between items; a finished result waits in
// the output register while the next sample is taken in.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mahony_quaternion_attitude_update_top_macros.svh"

module mahony_quaternion_attitude_update_top
    import mqa_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    // sample input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [23:0] s_rate_x,
    input  wire logic signed [23:0] s_rate_y,
    input  wire logic signed [23:0] s_rate_z,
    input  wire logic signed [15:0] s_accel_x,
    input  wire logic signed [15:0] s_accel_y,
    input  wire logic signed [15:0] s_accel_z,
    // attitude output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_quat_w,
    output logic signed [31:0]      m_quat_x,
    output logic signed [31:0]      m_quat_y,
    output logic signed [31:0]      m_quat_z,
    output logic                    m_accel_invalid
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_SQRT = 7'b0000100,
        S_DLD  = 7'b0001000,
        S_DRUN = 7'b0010000,
        S_DWB  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    // what the divider is working on
    typedef enum logic [1:0] {DK_UNIT, DK_CONST, DK_NORM} dkind_t;

    state_t state_reg;

    // configuration registers
    logic [31:0] kp_reg, ki_reg, dt_reg;

    // filter state
    logic signed [31:0] q_reg [4];
    logic signed [31:0] integ_reg [3];

    // sample and intermediate values
    logic signed [23:0] rate_reg [3];
    logic signed [15:0] acc_in_reg [3];
    logic signed [31:0] u_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] e_reg [3];
    logic signed [31:0] g_reg;
    logic signed [31:0] th_reg [3];
    logic [31:0]        d_reg;
    logic [33:0]        d2_reg;
    logic signed [33:0] t_reg [4];
    logic signed [31:0] nq_reg [4];
    logic signed [31:0] ca_reg, cb_reg;
    logic               invalid_reg;

    // microprogram sequencer and multiply-accumulate
    logic [5:0]         pc_reg;
    logic               ph_reg;
    logic signed [67:0] prod_reg;
    logic signed [69:0] acc_reg;

    // square root unit
    logic [63:0] sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [4:0]  sq_cnt_reg;

    // divider unit
    dkind_t      div_kind_reg;
    logic [1:0]  div_job_reg;
    logic [31:0] div_rem_reg, div_den_reg;
    logic [30:0] div_low_reg, div_quo_reg;
    logic [4:0]  div_cnt_reg;
    logic        div_ovf_reg, div_neg_reg;

    // output register
    logic               m_valid_reg;
    logic signed [31:0] out_q_reg [4];
    logic               out_inv_reg;

    uop_t               uop;
    opnd_t              sel [2];
    logic signed [33:0] opv [2];
    logic signed [69:0] prod_ext, prod_sh, acc_next;
    logic signed [33:0] wbv;

    assign uop = UCODE[pc_reg];
    assign sel[0] = uop.a;
    assign sel[1] = uop.b;

    // operand selection for the shared multiplier
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            case (sel[k])
                OP_Q0:   opv[k] = 34'(q_reg[0]);
                OP_Q1:   opv[k] = 34'(q_reg[1]);
                OP_Q2:   opv[k] = 34'(q_reg[2]);
                OP_Q3:   opv[k] = 34'(q_reg[3]);
                OP_AX:   opv[k] = 34'(acc_in_reg[0]);
                OP_AY:   opv[k] = 34'(acc_in_reg[1]);
                OP_AZ:   opv[k] = 34'(acc_in_reg[2]);
                OP_U0:   opv[k] = 34'(u_reg[0]);
                OP_U1:   opv[k] = 34'(u_reg[1]);
                OP_U2:   opv[k] = 34'(u_reg[2]);
                OP_V0:   opv[k] = 34'(v_reg[0]);
                OP_V1:   opv[k] = 34'(v_reg[1]);
                OP_V2:   opv[k] = 34'(v_reg[2]);
                OP_E0:   opv[k] = 34'(e_reg[0]);
                OP_E1:   opv[k] = 34'(e_reg[1]);
                OP_E2:   opv[k] = 34'(e_reg[2]);
                OP_I0:   opv[k] = 34'(integ_reg[0]);
                OP_I1:   opv[k] = 34'(integ_reg[1]);
                OP_I2:   opv[k] = 34'(integ_reg[2]);
                OP_R0:   opv[k] = 34'(rate_reg[0]);
                OP_R1:   opv[k] = 34'(rate_reg[1]);
                OP_R2:   opv[k] = 34'(rate_reg[2]);
                OP_G:    opv[k] = 34'(g_reg);
                OP_TH0:  opv[k] = 34'(th_reg[0]);
                OP_TH1:  opv[k] = 34'(th_reg[1]);
                OP_TH2:  opv[k] = 34'(th_reg[2]);
                OP_D:    opv[k] = $signed({2'b00, d_reg});
                OP_T0:   opv[k] = t_reg[0];
                OP_T1:   opv[k] = t_reg[1];
                OP_T2:   opv[k] = t_reg[2];
                OP_T3:   opv[k] = t_reg[3];
                OP_NQ0:  opv[k] = 34'(nq_reg[0]);
                OP_NQ1:  opv[k] = 34'(nq_reg[1]);
                OP_NQ2:  opv[k] = 34'(nq_reg[2]);
                OP_NQ3:  opv[k] = 34'(nq_reg[3]);
                OP_KP:   opv[k] = $signed({2'b00, kp_reg});
                OP_KI:   opv[k] = $signed({2'b00, ki_reg});
                OP_DT:   opv[k] = $signed({2'b00, dt_reg});
                OP_CA:   opv[k] = 34'(ca_reg);
                OP_CB:   opv[k] = 34'(cb_reg);
                OP_ONE:  opv[k] = 34'sd1;
                OP_C256: opv[k] = 34'sd256;
                default: opv[k] = 34'sd0;
            endcase
        end
    end

    // scale, accumulate and post-process
    always_comb begin
        prod_ext = 70'(prod_reg);
        case (uop.sh)
            SH_0:    prod_sh = prod_ext;
            SH_2:    prod_sh = prod_ext >>> 2;
            SH_18:   prod_sh = prod_ext >>> 18;
            SH_30:   prod_sh = prod_ext >>> 30;
            default: prod_sh = prod_ext;
        endcase
        case (uop.mode)
            AM_LOAD:  acc_next = prod_sh;
            AM_LOADN: acc_next = -prod_sh;
            AM_ADD:   acc_next = acc_reg + prod_sh;
            AM_SUB:   acc_next = acc_reg - prod_sh;
            default:  acc_next = prod_sh;
        endcase
        case (uop.post)
            PS_SAT:    wbv = clamp71(71'(acc_next), MIN32, MAX32);
            PS_SAT2:   wbv = clamp71($signed({acc_next, 1'b0}), MIN32, MAX32);
            PS_CLAMP1: wbv = clamp71(71'(acc_next), NEG1, POS1);
            PS_ASR30:  wbv = 34'(acc_next >>> 30);
            default:   wbv = acc_next[33:0];
        endcase
    end

    // square root step
    logic [63:0] sq_rb, sq_r_next;
    logic        sq_ge;
    always_comb begin
        sq_rb = sq_r_reg + sq_bit_reg;
        sq_ge = (sq_v_reg >= sq_rb);
        sq_r_next = sq_ge ? ((sq_r_reg >> 1) + sq_bit_reg) : (sq_r_reg >> 1);
    end

    // divider setup: magnitude shifted into place
    logic [63:0] dld_dvd;
    logic        dld_neg;
    logic [31:0] dld_den;
    logic [15:0] mag16;
    logic [31:0] mag32;
    always_comb begin
        dld_neg = 1'b0;
        dld_dvd = '0;
        dld_den = sq_r_reg[31:0];
        mag16 = '0;
        mag32 = '0;
        case (div_kind_reg)
            DK_UNIT: begin
                dld_neg = acc_in_reg[div_job_reg][15];
                mag16 = dld_neg ? 16'(-acc_in_reg[div_job_reg]) : acc_in_reg[div_job_reg];
                dld_dvd = {2'b00, mag16, 46'b0};
            end
            DK_NORM: begin
                dld_neg = nq_reg[div_job_reg][31];
                mag32 = dld_neg ? 32'(-nq_reg[div_job_reg]) : nq_reg[div_job_reg];
                dld_dvd = {1'b0, mag32, 31'b0};
            end
            default: begin
                dld_dvd = '0;
            end
        endcase
    end

    // divide by three for the series coefficients: reciprocal product,
    // exact for dividends below 2^33
    logic [27:0] c3_dvd;
    logic [59:0] c3_prod;
    logic [26:0] c3_quo;
    always_comb begin
        c3_dvd = div_job_reg[0] ? {1'b0, d2_reg[33:7]} : d_reg[31:4];
        c3_prod = c3_dvd * 32'hAAAA_AAAB;
        c3_quo = c3_prod[59:33];
    end

    // divider step and result shaping
    logic [32:0]        div_trial;
    logic               div_ge;
    logic [30:0]        div_res;
    logic signed [31:0] div_sres;
    always_comb begin
        div_trial = {div_rem_reg, div_low_reg[30]};
        div_ge = (div_trial >= {1'b0, div_den_reg});
        div_res = (div_ovf_reg || (div_quo_reg > 31'(ONE_Q30))) ? 31'(ONE_Q30) : div_quo_reg;
        div_sres = div_neg_reg ? -$signed({1'b0, div_res}) : $signed({1'b0, div_res});
    end

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_quat_w = out_q_reg[0];
    assign m_quat_x = out_q_reg[1];
    assign m_quat_y = out_q_reg[2];
    assign m_quat_z = out_q_reg[3];
    assign m_accel_invalid = out_inv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            pc_reg <= '0;
            ph_reg <= 1'b0;
            kp_reg <= 32'd503316480;
            ki_reg <= 32'd83886;
            dt_reg <= 32'd50332;
            q_reg[0] <= ONE_Q30;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
            integ_reg[0] <= '0;
            integ_reg[1] <= '0;
            integ_reg[2] <= '0;
        end else begin
            // configuration transfer
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_PROP_GAIN:     kp_reg <= cfg_data;
                    REG_INTEG_GAIN:    ki_reg <= cfg_data;
                    REG_SAMPLE_PERIOD: dt_reg <= cfg_data;
                    default: ;
                endcase
            end

            // output register fills from S_OUT, a result transfer frees it
            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        rate_reg[0] <= s_rate_x;
                        rate_reg[1] <= s_rate_y;
                        rate_reg[2] <= s_rate_z;
                        acc_in_reg[0] <= s_accel_x;
                        acc_in_reg[1] <= s_accel_y;
                        acc_in_reg[2] <= s_accel_z;
                        e_reg[0] <= '0;
                        e_reg[1] <= '0;
                        e_reg[2] <= '0;
                        invalid_reg <= 1'b0;
                        pc_reg <= '0;
                        ph_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end

                S_MUL: begin
                    if (!ph_reg) begin
                        prod_reg <= opv[0] * opv[1];
                        ph_reg <= 1'b1;
                    end else begin
                        ph_reg <= 1'b0;
                        acc_reg <= acc_next;
                        // zero accel vector jumps over the correction
                        if (uop.last && pc_reg == PC_END_SQ && acc_next == '0) begin
                            pc_reg <= PC_SEG_G;
                        end else begin
                            pc_reg <= pc_reg + 6'd1;
                        end
                        case (uop.dst)
                            DS_V0:  v_reg[0] <= wbv[31:0];
                            DS_V1:  v_reg[1] <= wbv[31:0];
                            DS_V2:  v_reg[2] <= wbv[31:0];
                            DS_E0:  e_reg[0] <= wbv[31:0];
                            DS_E1:  e_reg[1] <= wbv[31:0];
                            DS_E2:  e_reg[2] <= wbv[31:0];
                            DS_I0:  integ_reg[0] <= wbv[31:0];
                            DS_I1:  integ_reg[1] <= wbv[31:0];
                            DS_I2:  integ_reg[2] <= wbv[31:0];
                            DS_G:   g_reg <= wbv[31:0];
                            DS_TH0: th_reg[0] <= wbv[31:0];
                            DS_TH1: th_reg[1] <= wbv[31:0];
                            DS_TH2: th_reg[2] <= wbv[31:0];
                            DS_D:   d_reg <= wbv[31:0];
                            DS_D2:  d2_reg <= wbv;
                            DS_T0:  t_reg[0] <= wbv;
                            DS_T1:  t_reg[1] <= wbv;
                            DS_T2:  t_reg[2] <= wbv;
                            DS_T3:  t_reg[3] <= wbv;
                            DS_NQ0: nq_reg[0] <= wbv[31:0];
                            DS_NQ1: nq_reg[1] <= wbv[31:0];
                            DS_NQ2: nq_reg[2] <= wbv[31:0];
                            DS_NQ3: nq_reg[3] <= wbv[31:0];
                            default: ;
                        endcase
                        if (uop.last) begin
                            if (pc_reg == PC_END_SQ) begin
                                // zero accel vector: no correction, integral kept
                                if (acc_next == '0) begin
                                    invalid_reg <= 1'b1;
                                end else begin
                                    sq_v_reg <= {acc_next[31:0], 32'b0};
                                    sq_r_reg <= '0;
                                    sq_bit_reg <= 64'h4000_0000_0000_0000;
                                    sq_cnt_reg <= '0;
                                    state_reg <= S_SQRT;
                                end
                            end else if (pc_reg == PC_END_G) begin
                                div_kind_reg <= DK_CONST;
                                div_job_reg <= '0;
                                state_reg <= S_DWB;
                            end else begin
                                sq_v_reg <= acc_next[63:0];
                                sq_r_reg <= '0;
                                sq_bit_reg <= 64'h4000_0000_0000_0000;
                                sq_cnt_reg <= '0;
                                state_reg <= S_SQRT;
                            end
                        end
                    end
                end

                S_SQRT: begin
                    if (sq_ge) begin
                        sq_v_reg <= sq_v_reg - sq_rb;
                    end
                    sq_r_reg <= sq_r_next;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    if (sq_cnt_reg == 5'd31) begin
                        div_job_reg <= '0;
                        if (pc_reg == PC_SEG_VE) begin
                            div_kind_reg <= DK_UNIT;
                            state_reg <= S_DLD;
                        end else if (sq_r_next == '0) begin
                            // degenerate quaternion falls back to identity
                            q_reg[0] <= ONE_Q30;
                            q_reg[1] <= '0;
                            q_reg[2] <= '0;
                            q_reg[3] <= '0;
                            state_reg <= S_OUT;
                        end else begin
                            div_kind_reg <= DK_NORM;
                            state_reg <= S_DLD;
                        end
                    end
                end

                S_DLD: begin
                    div_ovf_reg <= (dld_dvd[63:31] >= {1'b0, dld_den});
                    div_rem_reg <= dld_dvd[62:31];
                    div_low_reg <= dld_dvd[30:0];
                    div_den_reg <= dld_den;
                    div_neg_reg <= dld_neg;
                    div_quo_reg <= '0;
                    div_cnt_reg <= '0;
                    state_reg <= S_DRUN;
                end

                S_DRUN: begin
                    div_rem_reg <= div_ge ? 32'(div_trial - {1'b0, div_den_reg})
                                          : div_trial[31:0];
                    div_quo_reg <= {div_quo_reg[29:0], div_ge};
                    div_low_reg <= {div_low_reg[29:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'd30) begin
                        state_reg <= S_DWB;
                    end
                end

                S_DWB: begin
                    div_job_reg <= div_job_reg + 2'd1;
                    case (div_kind_reg)
                        DK_UNIT: begin
                            u_reg[div_job_reg] <= div_sres;
                            if (div_job_reg == 2'd2) begin
                                state_reg <= S_MUL;
                            end else begin
                                state_reg <= S_DLD;
                            end
                        end
                        DK_CONST: begin
                            // d/48 first, then d^2/384 closes the series coefficients
                            if (div_job_reg[0]) begin
                                ca_reg <= ONE_Q30 - $signed({3'b000, d_reg[31:3]})
                                          + $signed({5'b00000, c3_quo});
                                state_reg <= S_MUL;
                            end else begin
                                cb_reg <= HALF_Q30 - $signed({5'b00000, c3_quo});
                                state_reg <= S_DWB;
                            end
                        end
                        default: begin
                            q_reg[div_job_reg] <= div_sres;
                            if (div_job_reg == 2'd3) begin
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_DLD;
                            end
                        end
                    endcase
                end

                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_q_reg[0] <= q_reg[0];
                        out_q_reg[1] <= q_reg[1];
                        out_q_reg[2] <= q_reg[2];
                        out_q_reg[3] <= q_reg[3];
                        out_inv_reg <= invalid_reg;
                        state_reg <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // short names for the checks below
    logic div_checked, seq_at_top, out_unit;
    assign div_checked = (state_reg == S_DRUN && !div_ovf_reg);
    assign seq_at_top = (state_reg == S_MUL && pc_reg == '0 && !ph_reg);
    assign out_unit = (out_q_reg[0] <= ONE_Q30 && out_q_reg[0] >= -ONE_Q30
                       && out_q_reg[3] <= ONE_Q30 && out_q_reg[3] >= -ONE_Q30);

    // remainder stays below the divisor while the quotient is in range
    `MQA_ASSERT_IMPL(a_div_rem, div_checked, (div_rem_reg < div_den_reg), "divider remainder")
    // an accepted sample starts the microprogram from the top
    `MQA_ASSERT_NEXT(a_start, (s_valid && s_ready), seq_at_top, "sequencer not started")
    // root search walks one bit pair per cycle
    `MQA_ASSERT_IMPL(a_sq_bit, (state_reg == S_SQRT), $onehot(sq_bit_reg), "root bit lost")
    // delivered w and z quaternion components are unit-range
    `MQA_ASSERT_IMPL(a_out_range, m_valid_reg, out_unit, "component beyond unit range")

endmodule

`default_nettype wire
